FILE: hw/rtl/rle2_pkg.sv
package rle2_pkg;

  // Width of the pixel counter and of the active part of the limit
  localparam int unsigned COUNT_BITS = 24;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned RUN_W   = 7;   // holds a run count of 1..64

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(76800);
  localparam logic [PIX_W-1:0]   RUN_MASK    = 8'h3F;

  // Stream parsing phase
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_CTRL = 3'd2,
    PH_LIT  = 3'd3,
    PH_VAL  = 3'd4
  } rle2_phase_e;

  // Mode field of a control byte
  typedef enum logic [1:0] {
    MODE_LIT    = 2'd0,
    MODE_SECOND = 2'd1,
    MODE_VALUE  = 2'd2,
    MODE_FIRST  = 2'd3
  } rle2_mode_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } rle2_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;   // accept the request on the input channel this cycle
    logic step;   // emit the next pixel of a pending run
  } rle2_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;      // more pixels of this byte follow
    logic out_free;  // output register can be loaded
  } rle2_sts_t;

endpackage

FILE: hw/rtl/rle2_if.sv
// Input channel: one stream byte per request
interface rle2_in_if import rle2_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_byte;
  logic             last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// Output channel: one decoded result per request
interface rle2_out_if import rle2_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel;
  logic               pixel_valid;
  logic               item_last;
  logic               stream_end;
  logic [LIMIT_W-1:0] zeros_owed;

  modport source (output valid, output pixel, output pixel_valid, output item_last,
                  output stream_end, output zeros_owed, input ready);
  modport sink   (input valid, input pixel, input pixel_valid, input item_last,
                  input stream_end, input zeros_owed, output ready);
endinterface

// Configuration write channel: pixel limit
interface rle2_cfg_if import rle2_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] out_limit;

  modport source (output valid, output out_limit, input ready);
  modport sink   (input valid, input out_limit, output ready);
endinterface

FILE: hw/rtl/rle2_ctrl.sv
module rle2_ctrl import rle2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rle2_sts_t sts_i,
  output rle2_cmd_t cmd_o
);

  rle2_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
        if (cmd_o.take && sts_i.more) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = sts_i.out_free;
        if (cmd_o.step && !sts_i.more) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/rle2_dp.sv
module rle2_dp import rle2_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rle2_cmd_t          cmd_i,
  output rle2_sts_t          sts_o,
  input  logic [PIX_W-1:0]   in_byte_i,
  input  logic               last_byte_i,
  input  logic               cfg_valid_i,
  input  logic [LIMIT_W-1:0] cfg_limit_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [PIX_W-1:0]   pixel_o,
  output logic               pixel_valid_o,
  output logic               item_last_o,
  output logic               stream_end_o,
  output logic [LIMIT_W-1:0] zeros_owed_o
);

  // Stream state
  rle2_phase_e           phase_q, phase_d;
  logic [PIX_W-1:0]      first_q, first_d;
  logic [PIX_W-1:0]      second_q, second_d;
  logic [RUN_W-1:0]      lit_left_q, lit_left_d;
  logic [RUN_W-1:0]      run_len_q, run_len_d;
  logic [COUNT_BITS-1:0] emitted_q, emitted_d;
  logic [LIMIT_W-1:0]    limit_q;

  // Pending run
  logic [PIX_W-1:0]      run_pix_q, run_pix_d;
  logic [RUN_W-1:0]      run_left_q, run_left_d;
  logic                  last_q, last_d;

  // Output register
  logic                  out_valid_q;
  logic [PIX_W-1:0]      pixel_q;
  logic                  pixel_valid_q, item_last_q, stream_end_q;
  logic [LIMIT_W-1:0]    owed_q;

  logic [COUNT_BITS-1:0] lim, inc, base;
  logic [COUNT_BITS:0]   diff;
  logic                  room, emit, more, end_flag, load, finish, no_header;
  logic [PIX_W-1:0]      pix;
  logic [RUN_W-1:0]      cnt, ctrl_cnt;
  rle2_mode_e            mode;
  logic [LIMIT_W-1:0]    owed;

  assign lim      = COUNT_BITS'(limit_q);
  assign room     = emitted_q < lim;
  assign mode     = rle2_mode_e'(in_byte_i[7:6]);
  assign ctrl_cnt = RUN_W'(in_byte_i & RUN_MASK) + RUN_W'(1);

  // Byte decode, run stepping and stream bookkeeping
  always_comb begin
    phase_d    = phase_q;
    first_d    = first_q;
    second_d   = second_q;
    lit_left_d = lit_left_q;
    run_len_d  = run_len_q;
    emitted_d  = emitted_q;
    run_pix_d  = run_pix_q;
    run_left_d = run_left_q;
    last_d     = last_q;
    emit       = 1'b0;
    pix        = '0;
    cnt        = '0;
    end_flag   = 1'b0;

    if (cmd_i.take) begin
      end_flag = last_byte_i;
      unique case (phase_q)
        PH_HDR0: begin
          first_d = in_byte_i;
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          second_d = in_byte_i;
          phase_d  = PH_CTRL;
        end
        PH_CTRL: begin
          if (room) begin
            unique case (mode)
              MODE_LIT: begin
                lit_left_d = ctrl_cnt;
                phase_d    = PH_LIT;
              end
              MODE_SECOND: begin
                emit = 1'b1;
                pix  = second_q;
                cnt  = ctrl_cnt;
              end
              MODE_VALUE: begin
                run_len_d = ctrl_cnt;
                phase_d   = PH_VAL;
              end
              MODE_FIRST: begin
                emit = 1'b1;
                pix  = first_q;
                cnt  = ctrl_cnt;
              end
              default: ;
            endcase
          end
        end
        PH_LIT: begin
          if (room) begin
            emit = 1'b1;
            pix  = in_byte_i;
            cnt  = RUN_W'(1);
            if (lit_left_q != '0) begin
              lit_left_d = lit_left_q - RUN_W'(1);
            end
            if (lit_left_d == '0) begin
              phase_d = PH_CTRL;
            end
          end
        end
        PH_VAL: begin
          if (room) begin
            emit    = 1'b1;
            pix     = in_byte_i;
            cnt     = run_len_q;
            phase_d = PH_CTRL;
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end else if (cmd_i.step) begin
      emit     = 1'b1;
      pix      = run_pix_q;
      cnt      = run_left_q;
      end_flag = last_q;
    end

    if (emit) begin
      emitted_d  = inc;
      run_pix_d  = pix;
      run_left_d = cnt - RUN_W'(1);
      last_d     = end_flag;
    end
  end

  // Pixel count, continuation test and pixels still owed to the limit
  assign inc       = emitted_q + COUNT_BITS'(1);
  assign more      = emit && (cnt > RUN_W'(1)) && (inc < lim);
  assign base      = emit ? inc : emitted_q;
  assign diff      = {1'b0, lim} - {1'b0, base};
  assign load      = emit || (cmd_i.take && last_byte_i);
  assign finish    = load && !more && end_flag;
  assign no_header = cmd_i.take && (phase_q == PH_HDR0);
  assign owed      = (finish && !no_header && !diff[COUNT_BITS])
                     ? LIMIT_W'(diff[COUNT_BITS-1:0]) : '0;

  assign sts_o.more     = more;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Stream state and limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      first_q    <= '0;
      second_q   <= '0;
      lit_left_q <= '0;
      run_len_q  <= '0;
      emitted_q  <= '0;
      limit_q    <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      // End of stream returns the stream state to its reset value; the limit is kept
      if (finish) begin
        phase_q    <= PH_HDR0;
        first_q    <= '0;
        second_q   <= '0;
        lit_left_q <= '0;
        run_len_q  <= '0;
        emitted_q  <= '0;
      end else begin
        phase_q    <= phase_d;
        first_q    <= first_d;
        second_q   <= second_d;
        lit_left_q <= lit_left_d;
        run_len_q  <= run_len_d;
        emitted_q  <= emitted_d;
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_limit_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Run and output payload
  always_ff @(posedge clk_i) begin
    run_pix_q  <= run_pix_d;
    run_left_q <= run_left_d;
    last_q     <= last_d;
    if (load) begin
      pixel_q       <= emit ? pix : '0;
      pixel_valid_q <= emit;
      item_last_q   <= !more;
      stream_end_q  <= finish;
      owed_q        <= owed;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_o       = pixel_q;
  assign pixel_valid_o = pixel_valid_q;
  assign item_last_o   = item_last_q;
  assign stream_end_o  = stream_end_q;
  assign zeros_owed_o  = owed_q;

endmodule

FILE: hw/rtl/rle_two_color_run_decoder_top.sv
// A byte's first result is registered and shows on the output in the cycle after the byte is taken.
// Throughput: a run of N pixels (N up to 64) holds the input until its last pixel has left,
// one pixel per cycle through the output register while the output is ready.
// Output stalls hold the input and the run sequencer.
// Reset (rst_ni low, asynchronous): stream state cleared, waits for the first header byte,
// pixel limit set to 76800.
module rle_two_color_run_decoder_top import rle2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rle2_in_if.sink     in_i,
  rle2_out_if.source  out_o,
  rle2_cfg_if.sink    cfg_i
);

  rle2_cmd_t cmd;
  rle2_sts_t sts;

  assign cfg_i.ready = 1'b1;

  rle2_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rle2_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_byte_i     (in_i.in_byte),
    .last_byte_i   (in_i.last_byte),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_limit_i   (cfg_i.out_limit),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .pixel_o       (out_o.pixel),
    .pixel_valid_o (out_o.pixel_valid),
    .item_last_o   (out_o.item_last),
    .stream_end_o  (out_o.stream_end),
    .zeros_owed_o  (out_o.zeros_owed)
  );

`ifndef SYNTHESIS
  // A stalled result must never be overwritten by a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input ready while output is stalled");

  // No new byte while a run is still being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_i.ready)
    else $error("input ready during a run");

  // Stream end closes the byte, and a bare marker only closes a stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.stream_end || !out_o.pixel_valid))
      |-> (out_o.item_last && out_o.stream_end))
    else $error("bad end marking");

  // Owed count only travels with the stream end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.stream_end) |-> (out_o.zeros_owed == '0))
    else $error("zeros_owed set before stream end");
`endif

endmodule

FILE: dv/rle_two_color_run_decoder_top_tb.sv
`timescale 1ns / 100ps

module rle_two_color_run_decoder_top_tb;
  import rle2_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int CFG_GAP         = 4;    // cycles let pass before a limit write
  localparam int END_GAP         = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_PX_PER_BYTE = 64;
  localparam int BATCH_ITEMS     = 12;
  localparam int NUM_MODES       = 5;

  // Idle percentages per traffic mode; the last mode adds a long receiver hold-off
  localparam int TX_IDLE_PCT [NUM_MODES] = '{0, 65, 0, 18, 0};
  localparam int RX_STALL_PCT[NUM_MODES] = '{0, 0, 65, 18, 0};

  // One decoded result as seen on the output channel
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic               pixel_valid;
    logic               item_last;
    logic               stream_end;
    logic [LIMIT_W-1:0] zeros_owed;
  } px_res_t;

  // One stream byte as offered on the input channel
  typedef struct packed {
    logic [PIX_W-1:0] data;
    logic             last;
  } stream_byte_t;

  typedef enum logic {
    ROW_BYTE  = 1'b0,
    ROW_LIMIT = 1'b1
  } row_kind_e;

  // Directed row: a stream byte or a limit write; typed rows carry their one result
  typedef struct packed {
    row_kind_e          kind;
    logic [LIMIT_W-1:0] val;
    logic               last;
    logic               typed;
    px_res_t            want;
  } dir_row_t;

  localparam px_res_t NO_RES  = '0;
  localparam int      NUM_DIR = 31;

  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // header cut short after one byte: bare end marker, nothing owed
    '{ROW_BYTE,  24'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 24'h0}},
    // full stream at the reset limit, every mode
    '{ROW_BYTE,  24'hAA, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h55, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'hC0, 1'b0, 1'b1, '{8'hAA, 1'b1, 1'b1, 1'b0, 24'h0}},
    '{ROW_BYTE,  24'h7F, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h02, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 24'h0}},
    '{ROW_BYTE,  24'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, 24'h0}},
    '{ROW_BYTE,  24'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0, 24'h0}},
    '{ROW_BYTE,  24'hBF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h05, 1'b0, 1'b0, NO_RES},
    // literal cut short by the end of the stream
    '{ROW_BYTE,  24'h11, 1'b1, 1'b0, NO_RES},
    // zero limit: control bytes ignored
    '{ROW_LIMIT, 24'h000000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h12, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h34, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h3F, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 24'h0}},
    // run crossing the limit, then end with the limit reached
    '{ROW_LIMIT, 24'h000005, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h01, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h02, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'hC9, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h40, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 24'h0}},
    // largest limit, value byte missing at the end
    '{ROW_LIMIT, 24'hFFFFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h10, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h20, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h81, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 24'hFFFFFF}},
    // limit lowered below the pixel count mid-stream: owed count saturates
    '{ROW_BYTE,  24'h10, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h20, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'hC3, 1'b0, 1'b0, NO_RES},
    '{ROW_LIMIT, 24'h000002, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  24'h81, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 24'h0}}
  };

  logic clk_i;
  logic rst_n;

  rle2_in_if  in_ch ();
  rle2_out_if out_ch ();
  rle2_cfg_if cfg_ch ();

  rle_two_color_run_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Decoder state mirrored by the predictor
  rle2_phase_e        dec_phase;
  logic [PIX_W-1:0]   color_a;
  logic [PIX_W-1:0]   color_b;
  logic [RUN_W-1:0]   lit_left;
  logic [RUN_W-1:0]   run_len;
  logic [31:0]        pix_count;
  logic [LIMIT_W-1:0] pix_limit;

  px_res_t pending_px[$];   // results still owed by the block
  int      err_count;
  int      quiet_cycles;
  int      tx_idle_pct;
  int      rx_stall_pct;
  int      hold_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_stream();
    dec_phase = PH_HDR0;
    color_a   = '0;
    color_b   = '0;
    lit_left  = '0;
    run_len   = '0;
    pix_count = '0;
  endfunction

  // Append up to cnt pixels, stopping at the limit
  task automatic emit_pixels(input logic [PIX_W-1:0] pix, input int unsigned cnt,
                             input logic [31:0] lim, ref px_res_t res[$]);
    int unsigned k;
    k = 0;
    while (k < cnt && pix_count < lim && res.size() < MAX_PX_PER_BYTE) begin
      res.insert(res.size(), {pix, 1'b1, 1'b0, 1'b0, {LIMIT_W{1'b0}}});
      pix_count++;
      k++;
    end
  endtask

  // Results caused by one stream byte; updates the mirrored state
  task automatic decode_byte(input logic [PIX_W-1:0] b, input logic last,
                             ref px_res_t res[$]);
    logic [31:0]  lim;
    logic [31:0]  owed;
    logic         room;
    int unsigned  cnt;
    rle2_mode_e   mode;
    res.delete();
    lim  = 32'(pix_limit) & 32'((33'd1 << COUNT_BITS) - 33'd1);
    room = pix_count < lim;
    cnt  = int'(b & RUN_MASK) + 1;
    mode = rle2_mode_e'(b[7:6]);
    case (dec_phase)
      PH_HDR0: begin
        color_a   = b;
        dec_phase = PH_HDR1;
      end
      PH_HDR1: begin
        color_b   = b;
        dec_phase = PH_CTRL;
      end
      PH_CTRL: begin
        if (room) begin
          case (mode)
            MODE_LIT: begin
              lit_left  = RUN_W'(cnt);
              dec_phase = PH_LIT;
            end
            MODE_SECOND: emit_pixels(color_b, cnt, lim, res);
            MODE_VALUE: begin
              run_len   = RUN_W'(cnt);
              dec_phase = PH_VAL;
            end
            default: emit_pixels(color_a, cnt, lim, res);
          endcase
        end
      end
      PH_LIT: begin
        if (room) begin
          emit_pixels(b, 1, lim, res);
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) dec_phase = PH_CTRL;
        end
      end
      PH_VAL: begin
        if (room) begin
          emit_pixels(b, run_len, lim, res);
          dec_phase = PH_CTRL;
        end
      end
      default: dec_phase = PH_HDR0;
    endcase

    // End of stream: owed count only once the header is complete
    if (last) begin
      owed = '0;
      if (dec_phase >= PH_CTRL && lim > pix_count) owed = lim - pix_count;
      if (res.size() == 0) res.insert(0, NO_RES);
      res[res.size()-1].stream_end = 1'b1;
      res[res.size()-1].zeros_owed = owed[LIMIT_W-1:0];
      clear_stream();
    end
    if (res.size() > 0) res[res.size()-1].item_last = 1'b1;
  endtask

  // Offer one byte; results are booked when the request is raised, before the byte is
  // taken and so before any of its results can show
  task automatic send_byte(input logic [PIX_W-1:0] b, input logic last,
                           input logic typed, input px_res_t want);
    px_res_t res[$];
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= last;
    decode_byte(b, last, res);
    if (typed) res = '{want};
    foreach (res[i]) pending_px.insert(pending_px.size(), res[i]);
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Limit write: only once every result is out and the block has settled
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (CFG_GAP) @(posedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.out_limit <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pix_limit = value;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return LIMIT_RESET;
      default: return LIMIT_W'($urandom_range(1, 300));
    endcase
  endfunction

  // One random stream: mostly well-formed, some cut short, some noise
  task automatic add_stream(ref stream_byte_t q[$]);
    stream_byte_t s[$];
    int           kind;
    int           groups;
    int           cnt;
    int           keep;
    rle2_mode_e   md;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      cnt = $urandom_range(1, 6);
      repeat (cnt) s.insert(s.size(), {8'($urandom), 1'b0});
    end else begin
      s.insert(s.size(), {8'($urandom), 1'b0});
      s.insert(s.size(), {8'($urandom), 1'b0});
      groups = $urandom_range(1, 6);
      repeat (groups) begin
        md = rle2_mode_e'($urandom_range(0, 3));
        if (md == MODE_LIT) begin
          cnt = $urandom_range(1, 8);
          s.insert(s.size(), {md, 6'(cnt - 1), 1'b0});
          repeat (cnt) s.insert(s.size(), {8'($urandom), 1'b0});
        end else begin
          s.insert(s.size(), {md, 6'($urandom), 1'b0});
          if (md == MODE_VALUE) s.insert(s.size(), {8'($urandom), 1'b0});
        end
      end
      // broken stream: end it at a random byte
      if (kind == 1) begin
        keep = $urandom_range(1, s.size());
        while (s.size() > keep) void'(s.pop_back());
      end
    end
    s[s.size()-1].last = 1'b1;
    foreach (s[i]) q.insert(q.size(), s[i]);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Output check against the oldest booked result
  always @(posedge clk_i) begin
    px_res_t got;
    px_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.pixel, out_ch.pixel_valid, out_ch.item_last, out_ch.stream_end,
             out_ch.zeros_owed};
      if (pending_px.size() == 0) begin
        $error("unexpected result: pixel %0h zeros_owed %0d", got.pixel, got.zeros_owed);
        err_count++;
      end else begin
        want = pending_px.pop_front();
        if (got.pixel !== want.pixel) begin
          $error("pixel: expected %0h, got %0h", want.pixel, got.pixel);
          err_count++;
        end
        if (got.pixel_valid !== want.pixel_valid) begin
          $error("pixel_valid: expected %0b, got %0b", want.pixel_valid, got.pixel_valid);
          err_count++;
        end
        if (got.item_last !== want.item_last) begin
          $error("item_last: expected %0b, got %0b", want.item_last, got.item_last);
          err_count++;
        end
        if (got.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
          err_count++;
        end
        if (got.zeros_owed !== want.zeros_owed) begin
          $error("zeros_owed: expected %0d, got %0d", want.zeros_owed, got.zeros_owed);
          err_count++;
        end
      end
    end
  end

  // Watchdog: cycles in which no request moves on any channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    stream_byte_t batch[$];
    int           md_i;
    int           sub;
    err_count        = 0;
    quiet_cycles     = 0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    hold_left        = 0;
    pix_limit        = LIMIT_RESET;
    clear_stream();
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= '0;
    in_ch.last_byte  <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.out_limit <= '0;
    rst_n            <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_LIMIT) begin
        write_limit(DIR_TAB[i].val);
      end else begin
        send_byte(DIR_TAB[i].val[PIX_W-1:0], DIR_TAB[i].last, DIR_TAB[i].typed,
                  DIR_TAB[i].want);
      end
    end

    // Random streams under each traffic mode, new limit per batch
    for (md_i = 0; md_i < NUM_MODES; md_i++) begin
      for (sub = 0; sub < 2; sub++) begin
        write_limit(pick_limit());
        tx_idle_pct  = TX_IDLE_PCT[md_i];
        rx_stall_pct = RX_STALL_PCT[md_i];
        batch.delete();
        while (batch.size() < BATCH_ITEMS) add_stream(batch);
        // receiver holds off while the sender keeps offering
        if (md_i == NUM_MODES - 1 && sub == 0) hold_left = HOLD_OFF_CYCLES;
        foreach (batch[i]) send_byte(batch[i].data, batch[i].last, 1'b0, NO_RES);
      end
    end

    // Drain and settle
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (END_GAP) @(posedge clk_i);
    if (pending_px.size() != 0) begin
      $error("%0d results never arrived", pending_px.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
